### rtl/msb_first_bit_reader_defines.svh
// Assertion macros for the MSB-first bit reader.
// Used by msb_first_bit_reader.sv; no other dependencies.
`ifndef MSB_FIRST_BIT_READER_DEFINES_SVH
`define MSB_FIRST_BIT_READER_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Property must hold on every clock edge outside reset
`define MFBR_ASSERT_ALWAYS(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define MFBR_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`else

`define MFBR_ASSERT_ALWAYS(lbl, clk, rstn, prop, msg)
`define MFBR_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)

`endif

`endif

### rtl/mfbr_pkg.sv
// Shared constants for the MSB-first bit reader.
// No dependencies; imported by msb_first_bit_reader.
package mfbr_pkg;

    // Buffer geometry
    localparam int BUFFER_BYTES = 4096;
    localparam int ADDR_W       = $clog2(BUFFER_BYTES);
    localparam int LEN_W        = $clog2(BUFFER_BYTES + 1);
    localparam int POS_W        = LEN_W + 3;

    // Word layout
    localparam int CNT_W        = 6;
    localparam int MAX_BITS     = 32;
    localparam int IN_DATA_W    = 16;
    localparam int OUT_DATA_W   = 40;

    // Item kinds carried in tuser
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_READ = 1'b1;

endpackage

### rtl/mfbr_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mfbr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/msb_first_bit_reader.sv
// MSB-first bit reader: a load word appends one byte to a 4096-byte buffer (restart clears
// length and position first; a byte that does not fit is dropped and flagged), a read word
// returns 1 to 32 bits taken most significant bit first, right aligned. One result word is
// produced per input word. The result of a load or a rejected read passes through the done
// state into the output register before the next word is taken. A read of N bits starting
// at bit offset F within the current byte touches B = (F + N - 1) / 8 + 1 bytes (at most
// 5): the buffer has one read port, fetched one byte per cycle, and a single byte merger
// folds each byte into the result. The first byte is fetched on acceptance and the rest in
// the read state; the result then passes through the done state into the output register,
// and only then is the next word taken. The input is ready again as soon as the result
// sits in the output register; while that register still holds an unaccepted word, the
// block waits for it to drain.
// Depends on mfbr_pkg, mfbr_ram and msb_first_bit_reader_defines.svh.
`include "msb_first_bit_reader_defines.svh"

module msb_first_bit_reader
    import mfbr_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // tdata: byte_value[7:0], restart[8], bit_count[14:9], zero[15]
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    input  logic [IN_DATA_W-1:0]  i_s_axis_tdata,
    // tuser: op[0]
    input  logic                  i_s_axis_tuser,
    // tdata: bits_value[31:0], bits_read[37:32], zero[39:38]
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    output logic [OUT_DATA_W-1:0] o_m_axis_tdata,
    // tuser: load_dropped[0]
    output logic                  o_m_axis_tuser
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_DONE
    } t_state;

    // Control registers
    t_state              r_state,     n_state;
    logic [LEN_W-1:0]    r_len,       n_len;
    logic [POS_W-1:0]    r_pos,       n_pos;
    logic                r_pend,      n_pend;
    logic [2:0]          r_iss_left,  n_iss_left;
    logic                r_out_valid, n_out_valid;
    // Payload registers
    logic [ADDR_W-1:0]   r_rd_addr,   n_rd_addr;
    logic [CNT_W-1:0]    r_remain,    n_remain;
    logic [2:0]          r_cpos,      n_cpos;
    logic [MAX_BITS-1:0] r_acc,       n_acc;
    logic [CNT_W-1:0]    r_cnt,       n_cnt;
    logic                r_drop,      n_drop;
    logic [OUT_DATA_W-1:0] r_out_data, n_out_data;
    logic                r_out_user,  n_out_user;

    // Input word fields
    logic                in_op;
    logic [7:0]          in_byte;
    logic                in_restart;
    logic [CNT_W-1:0]    in_count;
    logic                in_accept;

    // Read request check
    logic [POS_W:0]      rd_end;
    logic                rd_ok;
    logic [CNT_W-1:0]    rd_span;
    logic [LEN_W-1:0]    ld_len;

    // Byte merger
    logic [7:0]          mg_shifted;
    logic [3:0]          mg_avail;
    logic [3:0]          mg_take;
    logic [MAX_BITS+7:0] mg_merged;

    // Buffer ports
    logic                ram_we;
    logic [ADDR_W-1:0]   ram_waddr;
    logic                ram_re;
    logic [ADDR_W-1:0]   ram_raddr;
    logic [7:0]          ram_rdata;

    assign in_op      = i_s_axis_tuser;
    assign in_byte    = i_s_axis_tdata[7:0];
    assign in_restart = i_s_axis_tdata[8];
    assign in_count   = i_s_axis_tdata[14:9];
    assign in_accept  = i_s_axis_tvalid && o_s_axis_tready;

    // Bounds check of a read against the stored length
    assign rd_end  = {1'b0, r_pos} + (POS_W + 1)'(in_count);
    assign rd_ok   = (in_count != '0) && (in_count <= CNT_W'(MAX_BITS)) &&
                     (rd_end <= {1'b0, r_len, 3'b000});
    // Last bit index relative to the current byte; bits [5:3] give bytes beyond the first
    assign rd_span = CNT_W'(r_pos[2:0]) + in_count - CNT_W'(1);
    assign ld_len  = in_restart ? '0 : r_len;

    // Shared merger: fold the next bits of the fetched byte into the accumulator
    assign mg_shifted = ram_rdata << r_cpos;
    assign mg_avail   = 4'd8 - {1'b0, r_cpos};
    assign mg_take    = (r_remain < CNT_W'(mg_avail)) ? r_remain[3:0] : mg_avail;
    assign mg_merged  = {r_acc, mg_shifted} >> (4'd8 - mg_take);

    // Sequencer next-state logic
    always_comb begin
        n_state     = r_state;
        n_len       = r_len;
        n_pos       = r_pos;
        n_pend      = 1'b0;
        n_iss_left  = r_iss_left;
        n_rd_addr   = r_rd_addr;
        n_remain    = r_remain;
        n_cpos      = r_cpos;
        n_acc       = r_acc;
        n_cnt       = r_cnt;
        n_drop      = r_drop;
        n_out_valid = r_out_valid && !i_m_axis_tready;
        n_out_data  = r_out_data;
        n_out_user  = r_out_user;
        ram_we      = 1'b0;
        ram_waddr   = ld_len[ADDR_W-1:0];
        ram_re      = 1'b0;
        ram_raddr   = r_rd_addr;

        unique case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    n_acc  = '0;
                    n_cnt  = '0;
                    n_drop = 1'b0;
                    n_state = S_DONE;
                    if (in_op == OP_LOAD) begin
                        if (in_restart) begin
                            n_pos = '0;
                        end
                        if (ld_len < LEN_W'(BUFFER_BYTES)) begin
                            ram_we = 1'b1;
                            n_len  = ld_len + LEN_W'(1);
                        end else begin
                            n_len  = ld_len;
                            n_drop = 1'b1;
                        end
                    end else if (rd_ok) begin
                        // Fetch the first byte now, the rest from S_READ
                        ram_re     = 1'b1;
                        ram_raddr  = r_pos[ADDR_W+2:3];
                        n_pend     = 1'b1;
                        n_rd_addr  = r_pos[ADDR_W+2:3] + ADDR_W'(1);
                        n_iss_left = rd_span[5:3];
                        n_remain   = in_count;
                        n_cpos     = r_pos[2:0];
                        n_cnt      = in_count;
                        n_pos      = rd_end[POS_W-1:0];
                        n_state    = S_READ;
                    end
                end
            end
            S_READ: begin
                if (r_iss_left != '0) begin
                    ram_re     = 1'b1;
                    n_pend     = 1'b1;
                    n_rd_addr  = r_rd_addr + ADDR_W'(1);
                    n_iss_left = r_iss_left - 3'd1;
                end
                if (r_pend) begin
                    n_acc    = mg_merged[MAX_BITS-1:0];
                    n_remain = r_remain - CNT_W'(mg_take);
                    n_cpos   = 3'd0;
                    if (r_remain == CNT_W'(mg_take)) begin
                        n_state = S_DONE;
                    end
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_m_axis_tready) begin
                    n_out_valid = 1'b1;
                    n_out_data  = {2'b00, r_cnt, r_acc};
                    n_out_user  = r_drop;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_len       <= '0;
            r_pos       <= '0;
            r_pend      <= 1'b0;
            r_iss_left  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_len       <= n_len;
            r_pos       <= n_pos;
            r_pend      <= n_pend;
            r_iss_left  <= n_iss_left;
            r_out_valid <= n_out_valid;
        end
        r_rd_addr  <= n_rd_addr;
        r_remain   <= n_remain;
        r_cpos     <= n_cpos;
        r_acc      <= n_acc;
        r_cnt      <= n_cnt;
        r_drop     <= n_drop;
        r_out_data <= n_out_data;
        r_out_user <= n_out_user;
    end

    // Byte buffer
    mfbr_ram #(
        .WIDTH(8),
        .DEPTH(BUFFER_BYTES)
    ) u_buf (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (in_byte),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tuser  = r_out_user;

    // Checks
    `MFBR_ASSERT_ALWAYS(a_len_bound, i_clk, i_rst_n, r_len <= LEN_W'(BUFFER_BYTES), "stored length beyond buffer")
    `MFBR_ASSERT_ALWAYS(a_pos_bound, i_clk, i_rst_n, {1'b0, r_pos} <= {1'b0, r_len, 3'b000}, "read position beyond stored data")
    `MFBR_ASSERT_ALWAYS(a_read_left, i_clk, i_rst_n, (r_state != S_READ) || (r_remain != '0), "read sequence with no bits left")
    `MFBR_ASSERT_ALWAYS(a_out_count, i_clk, i_rst_n, !r_out_valid || (r_out_data[37:32] <= CNT_W'(MAX_BITS)), "bit count above limit")
    `MFBR_ASSERT_NEXT(a_drop_clean, i_clk, i_rst_n, n_out_valid && n_out_user && (r_state == S_DONE), r_out_data == '0, "dropped load with nonzero data")

endmodule
